// ===== rtl/spsu_pkg.sv =====
// Shared types, codes and helpers for the sparse polynomial store unit.
// No dependencies; spsu_qmul and the top-level file use these by scoped name.
`default_nettype none
package spsu_pkg;

	localparam int MAX_TERMS_DEF = 16;
	localparam int COEF_W        = 32;
	localparam int EXP_W         = 5;
	localparam int EXP_IN_W      = 6;
	localparam int ENTRY_W       = COEF_W + EXP_W;
	localparam int CNT_OUT_W     = 5;

	localparam logic signed [COEF_W-1:0] Q_ONE   = 32'sh0001_0000;
	localparam logic signed [COEF_W-1:0] Q_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [COEF_W-1:0] Q_MIN   = 32'sh8000_0000;
	localparam logic signed [COEF_W-1:0] Q_ZERO  = 32'sh0000_0000;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_EVAL   = 1'b1;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_REMOVED = 3'd1,
		ST_FULL    = 3'd2,
		ST_BADEXP  = 3'd3,
		ST_SAT     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SC_RD,
		S_SC_CHK,
		S_INS,
		S_SH_RD,
		S_SH_WR,
		S_RM_RD,
		S_RM_WR,
		S_EV_RD,
		S_EV_PW,
		S_EV_PWW,
		S_EV_TW
	} state_t;

	// Result beat of the shared fixed-point multiplier.
	typedef struct packed {
		logic                     valid;
		logic                     sat;
		logic signed [COEF_W-1:0] value;
	} mul_res_t;

	typedef struct packed {
		logic                     sat;
		logic signed [COEF_W-1:0] value;
	} add_res_t;

	// Saturating Q16.16 add.
	function automatic add_res_t sat_add(input logic signed [COEF_W-1:0] a,
		input logic signed [COEF_W-1:0] b);
		logic signed [COEF_W:0] s;
		add_res_t r;
		s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
		r.sat = s[COEF_W] != s[COEF_W-1];
		if (r.sat) begin
			r.value = s[COEF_W] ? Q_MIN : Q_MAX;
		end else begin
			r.value = s[COEF_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/spsu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module spsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/spsu_qmul.sv =====
// Shared Q16.16 multiplier: product stage, then round-half-up and saturate stage.
// Depends on spsu_pkg.
`default_nettype none
module spsu_qmul (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             go,
	input  wire logic signed [spsu_pkg::COEF_W-1:0] a,
	input  wire logic signed [spsu_pkg::COEF_W-1:0] b,
	output spsu_pkg::mul_res_t                    res
);

	logic signed [2*spsu_pkg::COEF_W-1:0] prod;
	logic signed [2*spsu_pkg::COEF_W-1:0] prod_s1;
	logic signed [2*spsu_pkg::COEF_W-1:0] rnd;
	logic signed [2*spsu_pkg::COEF_W-1:0] shf;
	logic                                 valid_s1;
	logic                                 valid_s2;
	logic                                 ovf;
	logic signed [spsu_pkg::COEF_W-1:0]   val_d;
	logic                                 sat_s2;
	logic signed [spsu_pkg::COEF_W-1:0]   val_s2;

	assign prod = a * b;

	// Arithmetic shift is floor division, so +0.5 then shift rounds half up.
	assign rnd = prod_s1 + 64'sh8000;
	assign shf = rnd >>> 16;
	assign ovf = !((&shf[63:31]) || !(|shf[63:31]));

	always_comb begin
		if (ovf) begin
			val_d = shf[63] ? spsu_pkg::Q_MIN : spsu_pkg::Q_MAX;
		end else begin
			val_d = shf[spsu_pkg::COEF_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= go;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		sat_s2  <= ovf;
		val_s2  <= val_d;
	end

	assign res.valid = valid_s2;
	assign res.sat   = sat_s2;
	assign res.value = val_s2;

endmodule
`default_nettype wire

// ===== rtl/sparse_polynomial_store_unit.sv =====
// Sparse polynomial store: sequencer, term RAM and shared multiplier.
// Depends on spsu_pkg, spsu_ram, spsu_qmul.
//
// Holds up to MAX_TERMS nonzero terms sorted by ascending exponent and takes
// one command beat when start is high and busy is low. Every command yields
// exactly one result beat: done is high for one cycle with value_out,
// term_count_out and status_out valid, and the result must be captured then
// since it cannot be held off. Terms sit in one RAM with a registered read,
// so every scan or shift step takes a read state, then a check or write state.
// An insert finishes from idle, without going busy, for a zero coefficient
// or a negative exponent; otherwise it scans up to the term's place, then
// updates the term there, removes it by moving later terms down, opens a
// new term by moving terms up, or refuses a new term when full. An evaluate
// walks the terms once and extends x^e incrementally through the two-stage
// multiplier.
// No clearing pass is needed after reset.
`default_nettype none
module sparse_polynomial_store_unit #(
	parameter int MAX_TERMS = spsu_pkg::MAX_TERMS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic                                  cmd,
	input  wire logic signed [spsu_pkg::COEF_W-1:0]    coef_in,
	input  wire logic signed [spsu_pkg::EXP_IN_W-1:0]  exp_in,
	input  wire logic signed [spsu_pkg::COEF_W-1:0]    x_in,
	output logic                                       busy,
	output logic                                       done,
	output logic signed [spsu_pkg::COEF_W-1:0]         value_out,
	output logic        [spsu_pkg::CNT_OUT_W-1:0]      term_count_out,
	output logic        [2:0]                          status_out
);

	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam int AW = $clog2(MAX_TERMS);
	localparam int EW = spsu_pkg::EXP_W;

	spsu_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] pos_q, pos_d;
	logic [CW-1:0] idx_m1, idx_p1;

	logic signed [spsu_pkg::COEF_W-1:0] coef_q, x_q;
	logic        [EW-1:0]               exp_q;
	logic signed [spsu_pkg::COEF_W-1:0] acc_q, acc_d;
	logic signed [spsu_pkg::COEF_W-1:0] pw_q, pw_d;
	logic        [EW-1:0]               pe_q, pe_d;
	logic                               sat_q, sat_d;

	logic                               we;
	logic [AW-1:0]                      waddr, raddr;
	logic [spsu_pkg::ENTRY_W-1:0]       wdata, rdata;
	logic        [EW-1:0]               rd_exp;
	logic signed [spsu_pkg::COEF_W-1:0] rd_coef;

	logic                               mul_go;
	logic signed [spsu_pkg::COEF_W-1:0] mul_a, mul_b;
	spsu_pkg::mul_res_t                 mul_res;

	spsu_pkg::add_res_t                 sum, accsum;

	logic                               fin;
	logic signed [spsu_pkg::COEF_W-1:0] fin_value;
	spsu_pkg::status_t                  fin_status;

	logic                               done_q;
	logic signed [spsu_pkg::COEF_W-1:0] value_q;
	logic [spsu_pkg::CNT_OUT_W-1:0]     tc_q;
	logic [2:0]                         status_q;

	logic                               accept;

	spsu_ram #(
		.WIDTH(spsu_pkg::ENTRY_W),
		.DEPTH(MAX_TERMS)
	) u_terms (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	spsu_qmul u_qmul (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (mul_go),
		.a     (mul_a),
		.b     (mul_b),
		.res   (mul_res)
	);

	assign accept  = start && !busy;
	assign busy    = state_q != spsu_pkg::S_IDLE;
	assign idx_m1  = idx_q - 1'b1;
	assign idx_p1  = idx_q + 1'b1;
	assign rd_exp  = rdata[spsu_pkg::ENTRY_W-1:spsu_pkg::COEF_W];
	assign rd_coef = rdata[spsu_pkg::COEF_W-1:0];
	assign sum     = spsu_pkg::sat_add(rd_coef, coef_q);
	assign accsum  = spsu_pkg::sat_add(acc_q, mul_res.value);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		idx_d      = idx_q;
		pos_d      = pos_q;
		acc_d      = acc_q;
		pw_d       = pw_q;
		pe_d       = pe_q;
		sat_d      = sat_q;
		we         = 1'b0;
		waddr      = idx_q[AW-1:0];
		wdata      = {exp_q, coef_q};
		raddr      = idx_q[AW-1:0];
		mul_go     = 1'b0;
		mul_a      = pw_q;
		mul_b      = x_q;
		fin        = 1'b0;
		fin_value  = spsu_pkg::Q_ZERO;
		fin_status = spsu_pkg::ST_OK;

		unique case (state_q)
			spsu_pkg::S_IDLE: begin
				idx_d = '0;
				if (accept) begin
					if (cmd == spsu_pkg::CMD_EVAL) begin
						acc_d   = spsu_pkg::Q_ZERO;
						pw_d    = spsu_pkg::Q_ONE;
						pe_d    = '0;
						sat_d   = 1'b0;
						state_d = spsu_pkg::S_EV_RD;
					end else if (coef_in == spsu_pkg::Q_ZERO) begin
						fin = 1'b1;
					end else if (exp_in[spsu_pkg::EXP_IN_W-1]) begin
						fin        = 1'b1;
						fin_status = spsu_pkg::ST_BADEXP;
					end else begin
						state_d = spsu_pkg::S_SC_RD;
					end
				end
			end
			spsu_pkg::S_SC_RD: begin
				if (idx_q == count_q) begin
					pos_d   = idx_q;
					state_d = spsu_pkg::S_INS;
				end else begin
					state_d = spsu_pkg::S_SC_CHK;
				end
			end
			spsu_pkg::S_SC_CHK: begin
				if (rd_exp < exp_q) begin
					idx_d   = idx_p1;
					state_d = spsu_pkg::S_SC_RD;
				end else if (rd_exp == exp_q) begin
					if (sum.value == spsu_pkg::Q_ZERO) begin
						state_d = spsu_pkg::S_RM_RD;
					end else begin
						we         = 1'b1;
						wdata      = {exp_q, sum.value};
						fin        = 1'b1;
						fin_status = sum.sat ? spsu_pkg::ST_SAT : spsu_pkg::ST_OK;
						state_d    = spsu_pkg::S_IDLE;
					end
				end else begin
					pos_d   = idx_q;
					state_d = spsu_pkg::S_INS;
				end
			end
			spsu_pkg::S_INS: begin
				if (count_q == CW'(MAX_TERMS)) begin
					fin        = 1'b1;
					fin_status = spsu_pkg::ST_FULL;
					state_d    = spsu_pkg::S_IDLE;
				end else begin
					idx_d   = count_q;
					state_d = spsu_pkg::S_SH_RD;
				end
			end
			spsu_pkg::S_SH_RD: begin
				// Open a hole at pos by moving entries up, top first.
				if (idx_q == pos_q) begin
					we      = 1'b1;
					count_d = count_q + 1'b1;
					fin     = 1'b1;
					state_d = spsu_pkg::S_IDLE;
				end else begin
					raddr   = idx_m1[AW-1:0];
					state_d = spsu_pkg::S_SH_WR;
				end
			end
			spsu_pkg::S_SH_WR: begin
				we      = 1'b1;
				wdata   = rdata;
				idx_d   = idx_m1;
				state_d = spsu_pkg::S_SH_RD;
			end
			spsu_pkg::S_RM_RD: begin
				// Close the gap by moving entries down, bottom first.
				if (idx_p1 == count_q) begin
					count_d    = count_q - 1'b1;
					fin        = 1'b1;
					fin_status = spsu_pkg::ST_REMOVED;
					state_d    = spsu_pkg::S_IDLE;
				end else begin
					raddr   = idx_p1[AW-1:0];
					state_d = spsu_pkg::S_RM_WR;
				end
			end
			spsu_pkg::S_RM_WR: begin
				we      = 1'b1;
				wdata   = rdata;
				idx_d   = idx_p1;
				state_d = spsu_pkg::S_RM_RD;
			end
			spsu_pkg::S_EV_RD: begin
				if (idx_q == count_q) begin
					fin        = 1'b1;
					fin_value  = acc_q;
					fin_status = sat_q ? spsu_pkg::ST_SAT : spsu_pkg::ST_OK;
					state_d    = spsu_pkg::S_IDLE;
				end else begin
					state_d = spsu_pkg::S_EV_PW;
				end
			end
			spsu_pkg::S_EV_PW: begin
				// Exponents ascend, so x^e carries over from the previous term.
				mul_go = 1'b1;
				if (pe_q == rd_exp) begin
					mul_a   = rd_coef;
					mul_b   = pw_q;
					state_d = spsu_pkg::S_EV_TW;
				end else begin
					state_d = spsu_pkg::S_EV_PWW;
				end
			end
			spsu_pkg::S_EV_PWW: begin
				if (mul_res.valid) begin
					pw_d    = mul_res.value;
					pe_d    = pe_q + 1'b1;
					sat_d   = sat_q || mul_res.sat;
					state_d = spsu_pkg::S_EV_PW;
				end
			end
			spsu_pkg::S_EV_TW: begin
				if (mul_res.valid) begin
					acc_d   = accsum.value;
					sat_d   = sat_q || mul_res.sat || accsum.sat;
					idx_d   = idx_p1;
					state_d = spsu_pkg::S_EV_RD;
				end
			end
			default: begin
				state_d = spsu_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spsu_pkg::S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			pos_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			pos_q   <= pos_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			coef_q <= coef_in;
			exp_q  <= exp_in[EW-1:0];
			x_q    <= x_in;
		end
		acc_q <= acc_d;
		pw_q  <= pw_d;
		pe_q  <= pe_d;
		sat_q <= sat_d;
		if (fin) begin
			value_q  <= fin_value;
			tc_q     <= spsu_pkg::CNT_OUT_W'(count_d);
			status_q <= fin_status;
		end
	end

	assign done           = done_q;
	assign value_out      = value_q;
	assign term_count_out = tc_q;
	assign status_out     = status_q;

`ifndef SYNTH
	a_done_follows_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(accept)))
		else $error("result beat without a command in flight");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TERMS))
		else $error("term count above capacity");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done))
		else $error("accepted command neither running nor finished");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_out == spsu_pkg::ST_FULL) |-> (count_q == CW'(MAX_TERMS)))
		else $error("full status with free entries");
`endif

endmodule
`default_nettype wire
